// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle, ignored during reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle, ignored during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle, checked through reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/lps_pkg.sv -----
// Types and constants for the line position and PD steering block.
`timescale 1ns / 1ps

package lps_pkg;

    localparam int SENSOR_W = 10;
    localparam int POS_W    = 11;
    localparam int SPEED_W  = 9;
    localparam int GAIN_W   = 12;
    localparam int NUM_W    = 22;
    localparam int DEN_W    = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam int FULL_SCALE = 1000;
    localparam int CENTRE_POS = 1000;
    localparam int MAX_POS    = 2000;
    localparam int DIV_STEPS  = POS_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD_GAIN          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_THRESHOLD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_THRESHOLD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MARKER_THRESHOLD = 3'd5;

    typedef struct packed {
        logic [SENSOR_W-1:0] curve_sensor;
        logic [SENSOR_W-1:0] left_line_sensor;
        logic [SENSOR_W-1:0] centre_line_sensor;
        logic [SENSOR_W-1:0] right_line_sensor;
        logic [SENSOR_W-1:0] finish_sensor;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0]   line_position;
        logic [SPEED_W-1:0] left_speed;
        logic [SPEED_W-1:0] right_speed;
        logic               curve_marker;
        logic               finish_marker;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] quot;
    } t_div_rsp;

endpackage

// ----- rtl/line_position_pd_steering.sv -----
// Line position from three middle sensors, marker flags and PD wheel steering.
// A request passes through the states NUM, DEC, DIV, ERR, KP, KD and OUT; DIV is skipped
// when the line is lost or the centroid is empty, and OUT waits for a free output register.
// No new request is taken until the result is stored. The block uses the 11-step serial divider
// and the single shared 13x13 multiplier used for the centroid, kp and kd terms.
// Reset (synchronous, active low) restores register defaults and clears last position/previous error.
`timescale 1ns / 1ps

module line_position_pd_steering (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  lps_pkg::t_in_item                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output lps_pkg::t_out_item               o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lps_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import lps_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_NUM, S_DEC, S_DIV, S_ERR, S_KP, S_KD, S_OUT
    } t_state;

    // Configuration registers
    logic [SPEED_W-1:0]  r_max_speed;
    logic [GAIN_W-1:0]   r_kp_gain;
    logic [GAIN_W-1:0]   r_kd_gain;
    logic [SENSOR_W-1:0] r_noise_thr;
    logic [SENSOR_W-1:0] r_line_thr;
    logic [SENSOR_W-1:0] r_marker_thr;

    // Sequencer and datapath
    t_state              r_state;
    logic [DEN_W-1:0]    r_wsum;
    logic [DEN_W-1:0]    r_den;
    logic [NUM_W-1:0]    r_num;
    logic                r_seen;
    logic                r_curve;
    logic                r_finish;
    logic [POS_W-1:0]    r_pos;
    logic [POS_W-1:0]    r_last_pos;
    logic signed [11:0]  r_prev_err;
    logic signed [10:0]  r_err;
    logic signed [11:0]  r_deriv;
    logic signed [25:0]  r_acc;
    logic                r_out_valid;
    t_out_item           r_out;

    logic [SENSOR_W-1:0] v_left, v_centre, v_right;
    logic [SENSOR_W-1:0] m_left, m_centre, m_right;
    logic [DEN_W-1:0]    n_den;
    logic [DEN_W-1:0]    n_wsum;
    logic                n_seen;
    logic [POS_W-1:0]    n_lost_pos;
    logic signed [11:0]  n_err;
    logic signed [11:0]  n_deriv;

    logic signed [12:0]  mul_a, mul_b;
    logic signed [25:0]  mul_p;

    logic signed [25:0]  acc_adj;
    logic signed [17:0]  pd_raw;
    logic signed [17:0]  ms_wide;
    logic signed [17:0]  pd_clamped;
    logic [SPEED_W-1:0]  n_left, n_right;
    logic                out_free;

    t_div_req            div_req;
    t_div_rsp            div_rsp;

    function automatic logic [SENSOR_W-1:0] invert_reading(input logic [SENSOR_W-1:0] r);
        logic [SENSOR_W-1:0] res;
        if (r > SENSOR_W'(FULL_SCALE)) begin
            res = '0;
        end else begin
            res = SENSOR_W'(FULL_SCALE) - r;
        end
        return res;
    endfunction

    // Input stage: invert, gate by noise threshold, form sums
    always_comb begin
        v_left   = invert_reading(i_in_data.left_line_sensor);
        v_centre = invert_reading(i_in_data.centre_line_sensor);
        v_right  = invert_reading(i_in_data.right_line_sensor);
        m_left   = (v_left   > r_noise_thr) ? v_left   : '0;
        m_centre = (v_centre > r_noise_thr) ? v_centre : '0;
        m_right  = (v_right  > r_noise_thr) ? v_right  : '0;
        n_den    = DEN_W'(m_left) + DEN_W'(m_centre) + DEN_W'(m_right);
        n_wsum   = DEN_W'(m_centre) + {1'b0, m_right, 1'b0};
        n_seen   = (v_left > r_line_thr) || (v_centre > r_line_thr)
                   || (v_right > r_line_thr);
    end

    assign n_lost_pos = (r_last_pos < POS_W'(CENTRE_POS)) ? '0 : POS_W'(MAX_POS);
    assign n_err      = 12'(CENTRE_POS) - signed'({1'b0, r_pos});
    assign n_deriv    = n_err - r_prev_err;

    // Shared multiplier: centroid numerator, kp term, kd term
    always_comb begin
        case (r_state)
            S_NUM: begin
                mul_a = signed'({1'b0, r_wsum});
                mul_b = 13'(FULL_SCALE);
            end
            S_KP: begin
                mul_a = signed'({1'b0, r_kp_gain});
                mul_b = 13'(r_err);
            end
            S_KD: begin
                mul_a = signed'({1'b0, r_kd_gain});
                mul_b = 13'(r_deriv);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Divide by 256 rounding toward zero, then clamp to +-max_speed
    always_comb begin
        acc_adj = r_acc + (r_acc[25] ? 26'sd255 : 26'sd0);
        pd_raw  = 18'(acc_adj >>> 8);
        ms_wide = signed'({9'b0, r_max_speed});
        if (pd_raw > ms_wide) begin
            pd_clamped = ms_wide;
        end else if (pd_raw < -ms_wide) begin
            pd_clamped = -ms_wide;
        end else begin
            pd_clamped = pd_raw;
        end
        if (pd_clamped > 18'sd0) begin
            n_left  = SPEED_W'(ms_wide - pd_clamped);
            n_right = r_max_speed;
        end else begin
            n_left  = r_max_speed;
            n_right = SPEED_W'(ms_wide + pd_clamped);
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    assign div_req.start = (r_state == S_DEC) && r_seen && (r_den != '0);
    assign div_req.num   = r_num;
    assign div_req.den   = r_den;

    lps_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed  <= 9'd180;
            r_kp_gain    <= 12'd115;
            r_kd_gain    <= 12'd1024;
            r_noise_thr  <= 10'd50;
            r_line_thr   <= 10'd200;
            r_marker_thr <= 10'd500;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAX_SPEED:        r_max_speed  <= i_cfg_data[SPEED_W-1:0];
                CFG_KP_GAIN:          r_kp_gain    <= i_cfg_data[GAIN_W-1:0];
                CFG_KD_GAIN:          r_kd_gain    <= i_cfg_data[GAIN_W-1:0];
                CFG_NOISE_THRESHOLD:  r_noise_thr  <= i_cfg_data[SENSOR_W-1:0];
                CFG_LINE_THRESHOLD:   r_line_thr   <= i_cfg_data[SENSOR_W-1:0];
                CFG_MARKER_THRESHOLD: r_marker_thr <= i_cfg_data[SENSOR_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last_pos  <= '0;
            r_prev_err  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_wsum   <= n_wsum;
                        r_den    <= n_den;
                        r_seen   <= n_seen;
                        r_curve  <= (i_in_data.curve_sensor < r_marker_thr);
                        r_finish <= (i_in_data.finish_sensor < r_marker_thr);
                        r_state  <= S_NUM;
                    end
                end
                S_NUM: begin
                    r_num   <= mul_p[NUM_W-1:0];
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    if (!r_seen) begin
                        r_pos   <= n_lost_pos;
                        r_state <= S_ERR;
                    end else if (r_den == '0) begin
                        r_pos   <= r_last_pos;
                        r_state <= S_ERR;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_pos      <= div_rsp.quot;
                        r_last_pos <= div_rsp.quot;
                        r_state    <= S_ERR;
                    end
                end
                S_ERR: begin
                    r_err      <= n_err[10:0];
                    r_deriv    <= n_deriv;
                    r_prev_err <= n_err;
                    r_state    <= S_KP;
                end
                S_KP: begin
                    r_acc   <= mul_p;
                    r_state <= S_KD;
                end
                S_KD: begin
                    r_acc   <= r_acc + mul_p;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_out.line_position <= r_pos;
                        r_out.left_speed    <= n_left;
                        r_out.right_speed   <= n_right;
                        r_out.curve_marker  <= r_curve;
                        r_out.finish_marker <= r_finish;
                        r_out_valid         <= 1'b1;
                        r_state             <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

// ----- rtl/lps_divider.sv -----
// Serial restoring divider for the centroid, one quotient bit per cycle.
`timescale 1ns / 1ps

module lps_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lps_pkg::t_div_req i_req,
    output lps_pkg::t_div_rsp o_rsp
);
    import lps_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [3:0]           r_cnt;
    logic [DEN_W-1:0]     r_rem;
    logic [DEN_W-1:0]     r_den;
    logic [POS_W-1:0]     r_quot;

    logic [DEN_W:0]       trial;
    logic [DEN_W:0]       diff;
    logic                 q_bit;
    logic [DEN_W-1:0]     n_rem;

    // Quotient fits in POS_W bits, so the upper numerator bits sit below den.
    assign trial = {r_rem, r_quot[POS_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign q_bit = (trial >= {1'b0, r_den});
    assign n_rem = q_bit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_req.start && (r_cnt == 4'(DIV_STEPS - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= {1'b0, i_req.num[NUM_W-1:POS_W]};
                r_quot <= i_req.num[POS_W-1:0];
                r_den  <= i_req.den;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_quot <= {r_quot[POS_W-2:0], q_bit};
                r_cnt  <= r_cnt + 4'd1;
                if (r_cnt == 4'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// ----- rtl/lps_checker.sv -----
// Port-level checker for the line position and PD steering block, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lps_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input lps_pkg::t_out_item               o_out_data
);
    import lps_pkg::*;

    logic in_take;
    logic out_wait;

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_wait = o_out_valid && i_out_stall;

    // a waiting result stays and holds its payload
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_wait, o_out_valid && $stable(o_out_data))
    // the block is busy right after it takes a request
    `ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, in_take, o_in_stall)
    // position never leaves its range
    `ASSERT_SAME(a_pos_range, i_clk, i_rst_n, o_out_valid, o_out_data.line_position <= 11'(MAX_POS))
    // reset empties the output register
    `ASSERT_NEXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !o_out_valid)

endmodule

bind line_position_pd_steering lps_checker u_lps_checker (.*);
